/* sv/tns_pkg.sv */
// shared constants, types and microcode table for the topology neighbor select block
package tns_pkg;

    localparam int NODE_W      = 12;
    localparam int COUNT_W     = 13;
    localparam int EDGE_W      = 7;
    localparam int MODE_W      = 3;
    localparam int FRAC_W      = 16;
    localparam int FRACTION_BITS = 16;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 16;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int PC_W        = 3;
    localparam int DIV_CNT_W   = 4;
    localparam int PROBE_W     = 14;

    localparam logic [MODE_W-1:0] MODE_HEX    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SQUARE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MESH   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BIRING = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RING   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_STAR   = 3'd5;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_NODES = 2'd1;
    localparam logic [1:0] REG_EDGE  = 2'd2;

    localparam logic [MODE_W-1:0]  RST_MODE  = MODE_HEX;
    localparam logic [COUNT_W-1:0] RST_NODES = 13'd1024;
    localparam logic [EDGE_W-1:0]  RST_EDGE  = 7'd32;

    localparam logic [2:0] DIR_LAST = 3'd5;

    localparam logic [PC_W-1:0] PC_WAIT  = 3'd0;
    localparam logic [PC_W-1:0] PC_CHECK = 3'd1;
    localparam logic [PC_W-1:0] PC_DIV   = 3'd2;
    localparam logic [PC_W-1:0] PC_DIR   = 3'd3;
    localparam logic [PC_W-1:0] PC_PROBE = 3'd4;
    localparam logic [PC_W-1:0] PC_MISS  = 3'd5;
    localparam logic [PC_W-1:0] PC_MUL   = 3'd6;
    localparam logic [PC_W-1:0] PC_OUT   = 3'd7;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_CHECK,
        OP_DIV,
        OP_DIR,
        OP_PROBE,
        OP_MISS,
        OP_MUL,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN,
        C_EARLY,
        C_DIV_LAST,
        C_HIT,
        C_GIVEUP,
        C_TAKEN
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] t_target;
        logic [PC_W-1:0] f_target;
    } t_uword;

    function automatic t_uword f_ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            PC_WAIT:  w = '{OP_LOAD,  C_IN,       PC_CHECK, PC_WAIT};
            PC_CHECK: w = '{OP_CHECK, C_EARLY,    PC_OUT,   PC_DIV};
            PC_DIV:   w = '{OP_DIV,   C_DIV_LAST, PC_DIR,   PC_DIV};
            PC_DIR:   w = '{OP_DIR,   C_ALWAYS,   PC_PROBE, PC_PROBE};
            PC_PROBE: w = '{OP_PROBE, C_HIT,      PC_MUL,   PC_MISS};
            PC_MISS:  w = '{OP_MISS,  C_GIVEUP,   PC_OUT,   PC_PROBE};
            PC_MUL:   w = '{OP_MUL,   C_ALWAYS,   PC_OUT,   PC_OUT};
            PC_OUT:   w = '{OP_OUT,   C_TAKEN,    PC_WAIT,  PC_OUT};
            default:  w = '{OP_OUT,   C_ALWAYS,   PC_WAIT,  PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

/* sv/topology_neighbor_select_core.sv */
// top level: microcoded neighbor selection over grid, ring, mesh and star topologies
// without a grid search, an item goes from the wait step through the check step to the output step
// grid modes: 1 check + 12 divider steps + 1 direction, then probe and miss per missed probe and
// probe and multiply for a hit, using the restoring divider and the hexagon direction search
// one item at a time: the next item is accepted the cycle after the result is taken
// reset is synchronous active low: sequencer to wait, config registers to reset values
module topology_neighbor_select_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // node_id [11:0], random_fraction [27:12], zero fill
    input  logic [tns_pkg::IN_DATA_W-1:0]         s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // receiver [11:0], retry [12], map_error [13], zero fill
    output logic [tns_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tns_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [tns_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [tns_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    logic [tns_pkg::PC_W-1:0]      r_pc,    n_pc;
    logic [tns_pkg::MODE_W-1:0]    r_mode;
    logic [tns_pkg::COUNT_W-1:0]   r_nodes;
    logic [tns_pkg::EDGE_W-1:0]    r_edge;
    logic [tns_pkg::NODE_W-1:0]    r_me,    n_me;
    logic [tns_pkg::FRAC_W-1:0]    r_frac,  n_frac;
    logic [tns_pkg::NODE_W-1:0]    r_quo,   n_quo;
    logic [tns_pkg::EDGE_W-1:0]    r_rem,   n_rem;
    logic [tns_pkg::DIV_CNT_W-1:0] r_cnt,   n_cnt;
    logic [2:0]                    r_dir,   n_dir;
    logic [2:0]                    r_tries, n_tries;
    logic [tns_pkg::EDGE_W-1:0]    r_nx,    n_nx;
    logic [tns_pkg::EDGE_W-1:0]    r_ny,    n_ny;
    logic [tns_pkg::NODE_W-1:0]    r_recv,  n_recv;
    logic                          r_retry, n_retry;
    logic                          r_merr,  n_merr;

    tns_pkg::t_uword               uw;
    logic                          cfg_wr;
    logic                          early;
    logic                          hit;
    logic                          giveup;
    logic                          jump;
    logic                          odd;
    logic [13:0]                   edge_sq;
    logic [28:0]                   scale;
    logic [18:0]                   hex_prod;
    logic [tns_pkg::COUNT_W-1:0]   me_inc;
    logic [tns_pkg::COUNT_W-1:0]   nodes_dec;
    logic [tns_pkg::NODE_W-1:0]    ring_next;
    logic [tns_pkg::EDGE_W:0]      div_t;
    logic                          div_ge;
    logic signed [tns_pkg::PROBE_W-1:0] sx, sy, se, nx, ny;
    logic [13:0]                   lin;

    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite;
    assign s_axis_tready = (r_pc == tns_pkg::PC_WAIT);
    assign m_axis_tvalid = (r_pc == tns_pkg::PC_OUT);
    assign m_axis_tdata  = {2'b00, r_merr, r_retry, r_recv};

    always_comb begin
        case (paddr[3:2])
            tns_pkg::REG_MODE:  prdata = 32'(r_mode);
            tns_pkg::REG_NODES: prdata = 32'(r_nodes);
            tns_pkg::REG_EDGE:  prdata = 32'(r_edge);
            default:            prdata = '0;
        endcase
    end

    assign uw        = tns_pkg::f_ucode(r_pc);
    assign edge_sq   = 14'(r_edge) * 14'(r_edge);
    assign scale     = 29'(r_nodes) * 29'(r_frac);
    assign hex_prod  = 19'(r_frac) * 19'd6;
    assign me_inc    = 13'(r_me) + 13'd1;
    assign nodes_dec = r_nodes - 13'd1;
    assign ring_next = (me_inc >= r_nodes) ? '0 : me_inc[11:0];
    assign div_t     = {r_rem, r_quo[tns_pkg::NODE_W-1]};
    assign div_ge    = div_t >= {1'b0, r_edge};
    assign odd       = r_quo[0];
    assign sx        = $signed(14'(r_rem));
    assign sy        = $signed(14'(r_quo));
    assign se        = $signed(14'(r_edge));
    assign lin       = 14'(r_ny) * 14'(r_edge) + 14'(r_nx);
    assign giveup    = (r_mode == tns_pkg::MODE_SQUARE) || (r_tries == tns_pkg::DIR_LAST);
    assign hit       = !nx[13] && !ny[13] && (nx < se) && (ny < se);

    // grid modes fall through to the divider unless the map is bad or trivial
    always_comb begin
        early = 1'b1;
        if (r_mode == tns_pkg::MODE_HEX || r_mode == tns_pkg::MODE_SQUARE) begin
            early = (r_edge == '0) || (edge_sq != 14'(r_nodes)) || (r_nodes == 13'd1);
        end
    end

    // neighbor coordinates for the current direction
    always_comb begin
        nx = sx;
        ny = sy;
        if (r_mode == tns_pkg::MODE_HEX) begin
            case (r_dir)
                3'd0: begin
                    nx = odd ? sx : sx - 14'sd1;
                    ny = sy - 14'sd1;
                end
                3'd1: nx = sx - 14'sd1;
                3'd2: begin
                    nx = odd ? sx : sx - 14'sd1;
                    ny = sy + 14'sd1;
                end
                3'd3: begin
                    nx = odd ? sx + 14'sd1 : sx;
                    ny = sy + 14'sd1;
                end
                3'd4: nx = sx + 14'sd1;
                default: begin
                    nx = odd ? sx + 14'sd1 : sx;
                    ny = sy - 14'sd1;
                end
            endcase
        end else begin
            case (r_dir)
                3'd0:    ny = sy - 14'sd1;
                3'd1:    nx = sx - 14'sd1;
                3'd2:    ny = sy + 14'sd1;
                default: nx = sx + 14'sd1;
            endcase
        end
    end

    always_comb begin
        case (uw.cond)
            tns_pkg::C_ALWAYS:   jump = 1'b1;
            tns_pkg::C_IN:       jump = s_axis_tvalid;
            tns_pkg::C_EARLY:    jump = early;
            tns_pkg::C_DIV_LAST: jump = (r_cnt == 4'(tns_pkg::NODE_W - 1));
            tns_pkg::C_HIT:      jump = hit;
            tns_pkg::C_GIVEUP:   jump = giveup;
            tns_pkg::C_TAKEN:    jump = m_axis_tready;
            default:             jump = 1'b1;
        endcase
        n_pc = jump ? uw.t_target : uw.f_target;
    end

    always_comb begin
        n_me    = r_me;
        n_frac  = r_frac;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_dir   = r_dir;
        n_tries = r_tries;
        n_nx    = r_nx;
        n_ny    = r_ny;
        n_recv  = r_recv;
        n_retry = r_retry;
        n_merr  = r_merr;
        case (uw.op)
            tns_pkg::OP_LOAD: begin
                if (s_axis_tvalid) begin
                    n_me    = s_axis_tdata[11:0];
                    n_frac  = s_axis_tdata[27:12];
                    n_quo   = s_axis_tdata[11:0];
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_recv  = '0;
                    n_retry = 1'b0;
                    n_merr  = 1'b0;
                end
            end
            tns_pkg::OP_CHECK: begin
                case (r_mode)
                    tns_pkg::MODE_HEX, tns_pkg::MODE_SQUARE: begin
                        if (r_edge == '0 || edge_sq != 14'(r_nodes)) begin
                            n_merr = 1'b1;
                        end else if (r_nodes == 13'd1) begin
                            n_recv = r_me;
                        end
                    end
                    tns_pkg::MODE_MESH: n_recv = scale[27:16];
                    tns_pkg::MODE_BIRING: begin
                        if (!r_frac[tns_pkg::FRACTION_BITS-1]) begin
                            if (r_me == '0) begin
                                n_recv = (r_nodes == '0) ? '0 : nodes_dec[11:0];
                            end else begin
                                n_recv = r_me - 12'd1;
                            end
                        end else begin
                            n_recv = ring_next;
                        end
                    end
                    tns_pkg::MODE_RING: n_recv = ring_next;
                    tns_pkg::MODE_STAR: n_recv = (r_me == '0) ? scale[27:16] : '0;
                    default:            n_recv = '0;
                endcase
            end
            tns_pkg::OP_DIV: begin
                n_rem = div_ge ? 7'(div_t - {1'b0, r_edge}) : div_t[6:0];
                n_quo = {r_quo[tns_pkg::NODE_W-2:0], div_ge};
                n_cnt = r_cnt + 4'd1;
            end
            tns_pkg::OP_DIR: begin
                n_dir   = (r_mode == tns_pkg::MODE_HEX) ? hex_prod[18:16]
                                                        : {1'b0, r_frac[15:14]};
                n_tries = '0;
            end
            tns_pkg::OP_PROBE: begin
                n_nx = nx[6:0];
                n_ny = ny[6:0];
            end
            tns_pkg::OP_MISS: begin
                if (r_mode == tns_pkg::MODE_SQUARE) begin
                    n_retry = 1'b1;
                end else begin
                    n_dir   = (r_dir == tns_pkg::DIR_LAST) ? 3'd0 : r_dir + 3'd1;
                    n_tries = r_tries + 3'd1;
                end
            end
            tns_pkg::OP_MUL: n_recv = lin[11:0];
            tns_pkg::OP_OUT: n_recv = r_recv;
            default:         n_recv = r_recv;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= tns_pkg::PC_WAIT;
            r_mode  <= tns_pkg::RST_MODE;
            r_nodes <= tns_pkg::RST_NODES;
            r_edge  <= tns_pkg::RST_EDGE;
        end else begin
            r_pc <= n_pc;
            if (cfg_wr) begin
                case (paddr[3:2])
                    tns_pkg::REG_MODE:  r_mode  <= pwdata[2:0];
                    tns_pkg::REG_NODES: r_nodes <= pwdata[12:0];
                    tns_pkg::REG_EDGE:  r_edge  <= pwdata[6:0];
                    default:            r_mode  <= r_mode;
                endcase
            end
        end
        r_me    <= n_me;
        r_frac  <= n_frac;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_dir   <= n_dir;
        r_tries <= n_tries;
        r_nx    <= n_nx;
        r_ny    <= n_ny;
        r_recv  <= n_recv;
        r_retry <= n_retry;
        r_merr  <= n_merr;
    end

endmodule

/* sv/tns_checker.sv */
// port-level checker for the topology neighbor select block, with its bind
module tns_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [tns_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item in flight
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("item accepted while result pending");

    // result never comes in the cycle right after accept
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result too early");

    // flags are exclusive and force receiver to zero
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[12] || m_axis_tdata[13])
        |-> !(m_axis_tdata[12] && m_axis_tdata[13]) && (m_axis_tdata[11:0] == '0))
        else $error("bad flag combination");

endmodule

bind topology_neighbor_select_core tns_checker u_tns_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
